/* hdl/esr_pkg.sv */
package esr_pkg;

    localparam int MaxSamples = 4096;
    localparam int MaxSegment = 1024;
    localparam int AddrW = $clog2(MaxSamples);
    localparam int CountW = AddrW + 1;
    localparam int EnergyW = 26;
    localparam int TotalW = 28;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_FETCH  = 2'd2;

    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    localparam logic [0:0] REG_KEEP_RATIO   = 1'b0;
    localparam logic [0:0] REG_SEGMENT_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_out;
        logic [12:0]        kept_length;
        logic [12:0]        segments_seen;
        logic               overflowed;
        logic               last_kept;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEG_RD,
        ST_SEG_WAIT,
        ST_MUL,
        ST_CMP,
        ST_SAMP_RD,
        ST_SAMP_WAIT,
        ST_FETCH_WAIT,
        ST_OUT
    } state_t;

endpackage

/* hdl/esr_ram.sv */
module esr_ram #(
    parameter int Width = 16,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/energy_silence_removal.sv */
// channel | direction | valid     | stall     | payload
// in      | into      | in_valid  | in_stall  | in_data   (in_item_t)
// out     | out of    | out_valid | out_stall | out_data  (out_item_t)
// cfg     | into      | cfg_we    | -         | cfg_index, cfg_data
// A push is stored in ST_IDLE without leaving that state; a fetch passes
// through ST_FETCH_WAIT and ST_OUT. Finish walks the store segment by
// segment, then sample by sample, set by the single read port of each memory.
// Reset clears the counters and control registers; the datapath registers and
// the memories are left undefined. A result waits in the output register while
// out_stall is high; no new item is taken until it is transferred.
module energy_silence_removal
    import esr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [15:0]        ratio_reg;
    logic [10:0]        segsz_reg;
    logic [CountW-1:0]  count_reg;
    logic [10:0]        pos_reg;
    logic [EnergyW-1:0] acc_reg;
    logic [CountW-1:0]  segs_reg;
    logic [EnergyW-1:0] min_reg;
    logic [TotalW-1:0]  total_reg;
    logic [CountW-1:0]  kept_reg;
    logic [CountW-1:0]  rptr_reg;
    logic               ovf_reg;
    logic [CountW-1:0]  i_reg, dst_reg, k_reg;
    logic               keep_reg;
    logic [EnergyW-1:0] e_reg;
    logic [44:0]        lhs_reg, rhs_reg;
    logic [TotalW-1:0]  diff_reg;
    logic               fetch_hit_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    // sample memory: 16-bit sample plus segment-end mark
    logic               s_we;
    logic [AddrW-1:0]   s_waddr, s_raddr;
    logic [16:0]        s_wdata, s_rdata;
    logic               e_we;
    logic [AddrW-1:0]   e_waddr, e_raddr;
    logic [EnergyW-1:0] e_wdata, e_rdata;

    esr_ram #(.Width(17), .Depth(MaxSamples)) u_samp (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );
    esr_ram #(.Width(EnergyW), .Depth(MaxSamples)) u_energy (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    logic        accept;
    logic [10:0] eff_size;
    logic [15:0] mag;
    logic [EnergyW-1:0] acc_sum;
    logic        push_ok, seg_end;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (segsz_reg == 11'd0)
            eff_size = 11'd1;
        else if (segsz_reg > 11'(MaxSegment))
            eff_size = 11'(MaxSegment);
        else
            eff_size = segsz_reg;
    end

    assign mag = in_data.sample_in[15] ? 16'(-in_data.sample_in) : in_data.sample_in;
    assign acc_sum = acc_reg + EnergyW'(mag);
    assign push_ok = accept && (in_data.opcode == OP_PUSH) && (count_reg < CountW'(MaxSamples));
    assign seg_end = (pos_reg + 11'd1) >= eff_size;

    // memory port control
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = count_reg[AddrW-1:0];
        s_wdata = {seg_end, in_data.sample_in};
        s_raddr = i_reg[AddrW-1:0];
        e_we    = push_ok && seg_end;
        e_waddr = segs_reg[AddrW-1:0];
        e_wdata = acc_sum;
        e_raddr = k_reg[AddrW-1:0];
        if (push_ok)
        begin
            s_we = 1'b1;
        end
        else if (state_reg == ST_SAMP_WAIT && keep_reg)
        begin
            s_we    = 1'b1;
            s_waddr = dst_reg[AddrW-1:0];
            s_wdata = s_rdata;
        end
        if (state_reg == ST_IDLE)
        begin
            s_raddr = rptr_reg[AddrW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.opcode == OP_FINISH)
                    state_next = ST_PREP;
                else if (accept && in_data.opcode == OP_FETCH)
                    state_next = ST_FETCH_WAIT;
            end
            ST_PREP:       state_next = ST_SEG_RD;
            ST_SEG_RD:
            begin
                if (i_reg >= count_reg || k_reg >= segs_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_SEG_WAIT;
            end
            ST_SEG_WAIT:   state_next = ST_MUL;
            ST_MUL:        state_next = ST_CMP;
            ST_CMP:        state_next = ST_SAMP_RD;
            ST_SAMP_RD:    state_next = ST_SAMP_WAIT;
            ST_SAMP_WAIT:
            begin
                if (s_rdata[16])
                    state_next = ST_SEG_RD;
                else if (i_reg + 1'b1 >= count_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_SAMP_RD;
            end
            ST_FETCH_WAIT: state_next = ST_OUT;
            ST_OUT:        state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= 16'd2048;
            segsz_reg     <= 11'd256;
            count_reg     <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            segs_reg      <= '0;
            min_reg       <= '0;
            total_reg     <= '0;
            kept_reg      <= '0;
            rptr_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            dst_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_KEEP_RATIO)
                    ratio_reg <= cfg_data;
                else
                    segsz_reg <= cfg_data[10:0];
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (accept && in_data.opcode == OP_PUSH)
            begin
                kept_reg <= '0;
                rptr_reg <= '0;
                if (!push_ok)
                    ovf_reg <= 1'b1;
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    if (seg_end)
                    begin
                        pos_reg   <= '0;
                        acc_reg   <= '0;
                        segs_reg  <= segs_reg + 1'b1;
                        total_reg <= total_reg + TotalW'(acc_sum);
                        if (segs_reg == '0 || acc_sum < min_reg)
                            min_reg <= acc_sum;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 11'd1;
                        acc_reg <= acc_sum;
                    end
                end
            end
            case (state_reg)
                ST_PREP:
                begin
                    i_reg   <= '0;
                    k_reg   <= '0;
                    dst_reg <= '0;
                end
                ST_SAMP_WAIT:
                begin
                    if (keep_reg)
                        dst_reg <= dst_reg + 1'b1;
                    if (s_rdata[16])
                        k_reg <= k_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (fetch_hit_reg)
                        rptr_reg <= rptr_reg + 1'b1;
                    if (!fetch_hit_reg && out_reg.kind == KIND_SUMMARY)
                    begin
                        kept_reg  <= dst_reg;
                        rptr_reg  <= '0;
                        count_reg <= '0;
                        pos_reg   <= '0;
                        acc_reg   <= '0;
                        segs_reg  <= '0;
                        min_reg   <= '0;
                        total_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                // hold a waiting result until it is transferred
                if (accept)
                begin
                    fetch_hit_reg <= (in_data.opcode == OP_FETCH) && (rptr_reg < kept_reg);
                    out_reg.kind  <= (in_data.opcode != OP_FETCH) ? KIND_SUMMARY :
                                     (rptr_reg < kept_reg) ? KIND_SAMPLE : KIND_EMPTY;
                end
                diff_reg <= total_reg - TotalW'(segs_reg) * TotalW'(min_reg);
            end
            ST_SEG_WAIT:
            begin
                e_reg <= e_rdata;
            end
            ST_MUL:
            begin
                lhs_reg <= 45'(segs_reg) * 45'(e_reg - min_reg);
                rhs_reg <= 45'(ratio_reg) * 45'(diff_reg);
            end
            ST_CMP:
            begin
                keep_reg <= {lhs_reg, 12'd0} > {12'd0, rhs_reg};
            end
            ST_FETCH_WAIT:
            begin
                out_reg.sample_out <= fetch_hit_reg ? $signed(s_rdata[15:0]) : 16'sd0;
                out_reg.last_kept  <= fetch_hit_reg && (rptr_reg + 1'b1 == kept_reg);
                out_reg.kept_length   <= '0;
                out_reg.segments_seen <= '0;
                out_reg.overflowed    <= 1'b0;
            end
            ST_OUT:
            begin
                if (!fetch_hit_reg && out_reg.kind == KIND_SUMMARY)
                begin
                    out_reg.sample_out    <= '0;
                    out_reg.last_kept     <= 1'b0;
                    out_reg.kept_length   <= dst_reg;
                    out_reg.segments_seen <= segs_reg;
                    out_reg.overflowed    <= ovf_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

/* bench/esr_checker.sv */
module esr_checker
    import esr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic signed [15:0] pcm [MaxSamples];
    logic [EnergyW-1:0] seg_energy [MaxSamples];
    logic               seg_end [MaxSamples];
    int unsigned        n_samples, seg_pos, n_segs, kept_cnt, rd_ptr;
    longint unsigned    acc, min_e, total;
    logic               ovf;
    logic [15:0]        ratio;
    logic [10:0]        seg_sz;
    out_item_t          results_due [$];

    task automatic clear_run();
        n_samples = 0;
        seg_pos = 0;
        n_segs = 0;
        acc = 0;
        min_e = 0;
        total = 0;
        ovf = 1'b0;
    endtask

    task automatic push_sample(input logic signed [15:0] s);
        int unsigned mag;
        int unsigned eff;
        kept_cnt = 0;
        rd_ptr = 0;
        if (n_samples >= MaxSamples)
        begin
            ovf = 1'b1;
            return;
        end
        mag = (s < 0) ? -int'(s) : int'(s);
        eff = (seg_sz == 0) ? 1 : (seg_sz > MaxSegment) ? MaxSegment : seg_sz;
        pcm[n_samples] = s;
        seg_end[n_samples] = 1'b0;
        acc += mag;
        seg_pos++;
        if (seg_pos >= eff)
        begin
            seg_end[n_samples] = 1'b1;
            seg_energy[n_segs % MaxSamples] = EnergyW'(acc);
            if (n_segs == 0 || acc < min_e)
                min_e = acc;
            total += acc;
            n_segs++;
            seg_pos = 0;
            acc = 0;
        end
        n_samples++;
    endtask

    // Compact kept segments to the front and queue the summary.
    task automatic decide_segments();
        int unsigned     k;
        int unsigned     dst;
        longint unsigned n;
        longint unsigned lhs;
        longint unsigned rhs;
        out_item_t       r;
        k = 0;
        dst = 0;
        n = n_segs;
        for (int unsigned i = 0; i < n_samples && i < MaxSamples; i++)
        begin
            if (k >= n_segs)
                break;
            lhs = 64'd4096 * n * (longint'(seg_energy[k % MaxSamples]) - min_e);
            rhs = longint'(ratio) * (total - n * min_e);
            if (lhs > rhs)
            begin
                pcm[dst] = pcm[i];
                dst++;
            end
            if (seg_end[i])
                k++;
        end
        kept_cnt = dst;
        rd_ptr = 0;
        r = '0;
        r.kind = KIND_SUMMARY;
        r.kept_length = 13'(kept_cnt);
        r.segments_seen = 13'(n_segs);
        r.overflowed = ovf;
        results_due.push_back(r);
        clear_run();
    endtask

    task automatic fetch_sample();
        out_item_t r;
        r = '0;
        if (rd_ptr < kept_cnt && rd_ptr < MaxSamples)
        begin
            r.kind = KIND_SAMPLE;
            r.sample_out = pcm[rd_ptr];
            r.last_kept = (rd_ptr + 1 == kept_cnt);
            rd_ptr++;
        end
        else
            r.kind = KIND_EMPTY;
        results_due.push_back(r);
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result kind=%0d", got.kind);
            errors++;
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
        end
        if (got.sample_out !== want.sample_out)
        begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
            errors++;
        end
        if (got.kept_length !== want.kept_length)
        begin
            $error("kept_length: expected %0d, got %0d", want.kept_length, got.kept_length);
            errors++;
        end
        if (got.segments_seen !== want.segments_seen)
        begin
            $error("segments_seen: expected %0d, got %0d",
                   want.segments_seen, got.segments_seen);
            errors++;
        end
        if (got.overflowed !== want.overflowed)
        begin
            $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
            errors++;
        end
        if (got.last_kept !== want.last_kept)
        begin
            $error("last_kept: expected %0d, got %0d", want.last_kept, got.last_kept);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_run();
            kept_cnt = 0;
            rd_ptr = 0;
            ratio = 16'd2048;
            seg_sz = 11'd256;
            errors = 0;
            results_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_result(out_data);
            if (cfg_we)
            begin
                if (cfg_index == REG_KEEP_RATIO)
                    ratio = cfg_data;
                else
                    seg_sz = cfg_data[10:0];
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.opcode)
                    OP_PUSH:   push_sample(in_data.sample_in);
                    OP_FINISH: decide_segments();
                    OP_FETCH:  fetch_sample();
                    default:   ;
                endcase
            end
        end
        pending = results_due.size();
    end

endmodule

/* bench/energy_silence_removal_test.sv */
module energy_silence_removal_test;
    import esr_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int QuietLimit = 200000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    out_item_t   out_data;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = REG_KEEP_RATIO;
    logic [15:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          items = 0;
    int          quiet = 0;
    int          level = 0;
    bit          hold_req = 0;
    bit          held = 0;

    energy_silence_removal uut (.*);

    esr_checker chk (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always
    begin
        @(posedge clk);
        if (hold_req && !held)
        begin
            out_stall <= 1;
            repeat (400) @(posedge clk);
            held = 1;
        end
        out_stall <= ($urandom_range(99) < rcv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QuietLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_idling();
        if (items < 450)
        begin
            snd_idle = 31;
            rcv_idle = 59;
        end
        else if (items < 900)
        begin
            snd_idle = 59;
            rcv_idle = 31;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
    endtask

    task automatic send(input logic [1:0] op, input logic signed [15:0] s);
        int gap;
        set_idling();
        gap = 0;
        while ($urandom_range(99) < snd_idle)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data.opcode <= op;
        in_data.sample_in <= s;
        // hold until the transfer happens
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        items++;
    endtask

    task automatic settle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Loudness drifts in runs so segments differ in energy.
    function automatic logic [15:0] audio_sample();
        if ($urandom_range(7) == 0)
            level = $urandom_range(3);
        case (level)
            0: return 16'($signed($urandom_range(8)) - 4);
            1: return 16'($signed($urandom_range(400)) - 200);
            2: return 16'($signed($urandom_range(10000)) - 5000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int pushes, input int fetches);
        for (int i = 0; i < pushes; i++)
        begin
            if ($urandom_range(99) < 3)
                send($urandom_range(1) ? OP_NOP : OP_FETCH, 16'($urandom));
            send(OP_PUSH, audio_sample());
        end
        send(OP_FINISH, 16'($urandom));
        for (int i = 0; i < fetches; i++)
            send(OP_FETCH, 16'($urandom));
    endtask

    initial
    begin
        logic [15:0] sz;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Extreme samples, ratio zero, trailing partial segment.
        write_cfg(REG_KEEP_RATIO, 16'd0);
        write_cfg(REG_SEGMENT_SIZE, 16'd2);
        send(OP_PUSH, 16'sh7fff);
        send(OP_PUSH, -16'sh8000);
        send(OP_PUSH, 16'sd0);
        send(OP_PUSH, 16'sd1);
        send(OP_PUSH, -16'sd1);
        send(OP_FINISH, 16'sd0);
        repeat (5) send(OP_FETCH, 16'sd0);
        send(OP_NOP, -16'sd1);
        settle();
        // Zero size acts as one; max ratio; no segments; push drops unread samples.
        write_cfg(REG_KEEP_RATIO, 16'hffff);
        write_cfg(REG_SEGMENT_SIZE, 16'd0);
        send(OP_FINISH, 16'sd0);
        send(OP_FETCH, 16'sd0);
        send(OP_PUSH, 16'sd3);
        send(OP_PUSH, 16'sd900);
        send(OP_PUSH, -16'sd50);
        send(OP_FINISH, 16'sd0);
        send(OP_FETCH, 16'sd0);
        send(OP_PUSH, 16'sd7);
        send(OP_FETCH, 16'sd0);
        send(OP_FINISH, 16'sd0);
        settle();

        // Oversized setting clamps to the largest segment; partial tail dropped.
        write_cfg(REG_SEGMENT_SIZE, 16'd2047);
        write_cfg(REG_KEEP_RATIO, 16'($urandom_range(8192)));
        run_phase(1030, 10);
        settle();

        while (items < 1400)
        begin
            case ($urandom_range(9))
                0: sz = 16'd1024;
                1: sz = 16'd1;
                default: sz = 16'($urandom_range(12) + 2);
            endcase
            write_cfg(REG_SEGMENT_SIZE, sz);
            case ($urandom_range(5))
                0: write_cfg(REG_KEEP_RATIO, 16'd0);
                1: write_cfg(REG_KEEP_RATIO, 16'hffff);
                2: write_cfg(REG_KEEP_RATIO, 16'($urandom));
                default: write_cfg(REG_KEEP_RATIO, 16'($urandom_range(8192)));
            endcase
            run_phase($urandom_range(60), $urandom_range(60));
            if (!hold_req)
            begin
                hold_req = 1;
                repeat (30) send(OP_FETCH, 16'sd0);
            end
            settle();
        end

        settle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
